// ===== rtl/qn_pkg.sv =====
// ----------------------------------------------------------------------------
// qn_pkg: shared constants for the quaternion normalizer
// Default component and fraction widths and the derived data widths.
// ----------------------------------------------------------------------------
package qn_pkg;
  localparam int unsigned QnInWidth    = 16;
  localparam int unsigned QnOutFracBits = 14;

  // Bytes-rounded width of a packed group of four fields
  function automatic int unsigned qn_pad4(input int unsigned fw);
    return ((4 * fw + 7) / 8) * 8;
  endfunction
endpackage

// ===== rtl/quaternion_normalizer_core.sv =====
// ----------------------------------------------------------------------------
// quaternion_normalizer_core: unit quaternion from four fixed-point parts
//
//  Port group  Dir  tdata (low bit up)                 tuser
//  s_axis      in   w_in, x_in, y_in, z_in             -
//  m_axis      out  w_out, x_out, y_out, z_out         zero_norm
//
// One word per cycle sustained while the output is not stalled. Stages:
// two prep stages, one search stage per result bit, one output stage.
// Reset clears only the valid bits. The whole pipeline holds when the
// output word is stalled; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module quaternion_normalizer_core
  import qn_pkg::*;
#(
  parameter int unsigned IN_WIDTH      = QnInWidth,
  parameter int unsigned OUT_FRAC_BITS = QnOutFracBits,
  localparam int unsigned OW  = OUT_FRAC_BITS + 2,
  localparam int unsigned SW  = 2 * IN_WIDTH + 1,
  localparam int unsigned RW  = 2 * IN_WIDTH + 2 * OUT_FRAC_BITS + 6,
  localparam int unsigned NW  = OUT_FRAC_BITS + 1,
  localparam int unsigned IDW = qn_pad4(IN_WIDTH),
  localparam int unsigned ODW = qn_pad4(OW)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_axis_tvalid_i,
  output logic           s_axis_tready_o,
  input  logic [IDW-1:0] s_axis_tdata_i,   // w_in, x_in, y_in, z_in
  output logic           m_axis_tvalid_o,
  input  logic           m_axis_tready_i,
  output logic [ODW-1:0] m_axis_tdata_o,   // w_out, x_out, y_out, z_out
  output logic           m_axis_tuser_o    // zero_norm
);
  logic                       en;
  logic signed [IN_WIDTH-1:0] comp [4];
  logic                       vld_c  [NW+1];
  logic [SW-1:0]              sum_c  [NW+1];
  logic signed [RW-1:0]       res_c  [NW+1][4];
  logic signed [RW-1:0]       slp_c  [NW+1][4];
  logic [NW-1:0]              n_c    [NW+1][4];
  logic                       neg_c  [NW+1][4];
  logic                       zero_c [NW+1];
  logic                       out_vld_q;
  logic [4*OW-1:0]            out_data_q;
  logic                       out_zero_q;
  logic [4*OW-1:0]            out_data_d;

  // global advance: output free or being taken
  assign en = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  always_comb begin
    for (int i = 0; i < 4; i++) comp[i] = s_axis_tdata_i[i*IN_WIDTH +: IN_WIDTH];
  end

  qn_prep #(.IN_WIDTH(IN_WIDTH), .OUT_FRAC_BITS(OUT_FRAC_BITS)) u_prep (
    .clk_i, .rst_ni, .en_i(en), .vld_i(s_axis_tvalid_i), .comp_i(comp),
    .vld_o(vld_c[0]), .sum_o(sum_c[0]), .res_o(res_c[0]), .slp_o(slp_c[0]),
    .neg_o(neg_c[0]), .zero_o(zero_c[0])
  );

  always_comb begin
    for (int i = 0; i < 4; i++) n_c[0][i] = '0;
  end

  // search chain, most significant result bit first
  for (genvar g = 0; g < NW; g++) begin : g_step
    qn_step #(.IN_WIDTH(IN_WIDTH), .OUT_FRAC_BITS(OUT_FRAC_BITS), .BIT(NW - 1 - g)) u_step (
      .clk_i, .rst_ni, .en_i(en),
      .vld_i(vld_c[g]), .sum_i(sum_c[g]), .res_i(res_c[g]), .slp_i(slp_c[g]),
      .n_i(n_c[g]), .neg_i(neg_c[g]), .zero_i(zero_c[g]),
      .vld_o(vld_c[g+1]), .sum_o(sum_c[g+1]), .res_o(res_c[g+1]), .slp_o(slp_c[g+1]),
      .n_o(n_c[g+1]), .neg_o(neg_c[g+1]), .zero_o(zero_c[g+1])
    );
  end

  // sign and zero-norm override
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (zero_c[NW]) out_data_d[i*OW +: OW] = '0;
      else if (neg_c[NW][i]) out_data_d[i*OW +: OW] = -OW'(n_c[NW][i]);
      else out_data_d[i*OW +: OW] = OW'(n_c[NW][i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (en) out_vld_q <= vld_c[NW];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= out_data_d;
      out_zero_q <= zero_c[NW];
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = ODW'(out_data_q);
  assign m_axis_tuser_o  = out_zero_q;

  // zero-norm words carry all-zero components
  a_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o == '0)
    else $error("zero-norm word with nonzero data");

  // a stalled output word freezes the pipeline input
  a_stall_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("input taken while output stalled");

  // a taken word with nothing behind it leaves output empty
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && !vld_c[NW] |=> !m_axis_tvalid_o)
    else $error("output word repeated");
endmodule

// ===== rtl/qn_prep.sv =====
// ----------------------------------------------------------------------------
// qn_prep: front stages of the normalizer
// Stage 1 takes magnitudes and squares, stage 2 sums them and seeds the
// residual and slope terms of the rounding search.
// ----------------------------------------------------------------------------
module qn_prep
  import qn_pkg::*;
#(
  parameter int unsigned IN_WIDTH      = QnInWidth,
  parameter int unsigned OUT_FRAC_BITS = QnOutFracBits,
  localparam int unsigned SW = 2 * IN_WIDTH + 1,
  localparam int unsigned RW = 2 * IN_WIDTH + 2 * OUT_FRAC_BITS + 6
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       vld_i,
  input  logic signed [IN_WIDTH-1:0] comp_i [4],
  output logic                       vld_o,
  output logic        [SW-1:0]       sum_o,
  output logic signed [RW-1:0]       res_o [4],
  output logic signed [RW-1:0]       slp_o [4],
  output logic                       neg_o [4],
  output logic                       zero_o
);
  logic                      vld1_q;
  logic [2*IN_WIDTH-1:0]     sq_q  [4];
  logic                      neg1_q [4];
  logic                      vld2_q;
  logic [SW-1:0]             sum_q;
  logic signed [RW-1:0]      res_q [4];
  logic signed [RW-1:0]      slp_q [4];
  logic                      neg2_q [4];
  logic [IN_WIDTH-1:0]       mag   [4];
  logic [SW-1:0]             sum_d;
  logic signed [RW-1:0]      sum_ext;

  // magnitudes (most negative value fits unsigned)
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mag[i] = comp_i[i][IN_WIDTH-1] ? IN_WIDTH'(-comp_i[i]) : comp_i[i];
    end
  end

  assign sum_d = SW'(sq_q[0]) + SW'(sq_q[1]) + SW'(sq_q[2]) + SW'(sq_q[3]);
  assign sum_ext = signed'(RW'(sum_d));

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
    end
  end

  // payload: squares, then sum and search seeds
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 4; i++) begin
        sq_q[i]   <= mag[i] * mag[i];
        neg1_q[i] <= comp_i[i][IN_WIDTH-1];
        // residual = a^2 * 2^(2F+2) - S, slope = -S
        res_q[i]  <= (signed'(RW'(sq_q[i])) <<< (2 * OUT_FRAC_BITS + 2)) - sum_ext;
        slp_q[i]  <= -sum_ext;
        neg2_q[i] <= neg1_q[i];
      end
      sum_q <= sum_d;
    end
  end

  assign vld_o  = vld2_q;
  assign sum_o  = sum_q;
  assign res_o  = res_q;
  assign slp_o  = slp_q;
  assign neg_o  = neg2_q;
  assign zero_o = (sum_q == '0);
endmodule

// ===== rtl/qn_step.sv =====
// ----------------------------------------------------------------------------
// qn_step: one bit of the rounded quotient search
// Tries setting bit BIT of n for all four lanes: accepts when
// (2n-1)^2 * S <= a^2 * 2^(2F+2), tracked as a residual and a slope.
// ----------------------------------------------------------------------------
module qn_step
  import qn_pkg::*;
#(
  parameter int unsigned IN_WIDTH      = QnInWidth,
  parameter int unsigned OUT_FRAC_BITS = QnOutFracBits,
  parameter int unsigned BIT           = 0,
  localparam int unsigned SW = 2 * IN_WIDTH + 1,
  localparam int unsigned RW = 2 * IN_WIDTH + 2 * OUT_FRAC_BITS + 6,
  localparam int unsigned NW = OUT_FRAC_BITS + 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 vld_i,
  input  logic [SW-1:0]        sum_i,
  input  logic signed [RW-1:0] res_i [4],
  input  logic signed [RW-1:0] slp_i [4],
  input  logic [NW-1:0]        n_i   [4],
  input  logic                 neg_i [4],
  input  logic                 zero_i,
  output logic                 vld_o,
  output logic [SW-1:0]        sum_o,
  output logic signed [RW-1:0] res_o [4],
  output logic signed [RW-1:0] slp_o [4],
  output logic [NW-1:0]        n_o   [4],
  output logic                 neg_o [4],
  output logic                 zero_o
);
  logic                 vld_q, zero_q;
  logic [SW-1:0]        sum_q;
  logic signed [RW-1:0] res_q [4];
  logic signed [RW-1:0] slp_q [4];
  logic [NW-1:0]        n_q   [4];
  logic                 neg_q [4];
  logic signed [RW-1:0] sum_ext;
  logic signed [RW-1:0] trial [4];

  assign sum_ext = signed'(RW'(sum_i));

  // trial residual with bit set
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      trial[i] = res_i[i] - (slp_i[i] <<< (BIT + 2)) - (sum_ext <<< (2 * BIT + 2));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= 1'b0;
    else if (en_i) vld_q <= vld_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 4; i++) begin
        if (!trial[i][RW-1]) begin
          res_q[i] <= trial[i];
          slp_q[i] <= slp_i[i] + (sum_ext <<< (BIT + 1));
          n_q[i]   <= n_i[i] | (NW'(1) << BIT);
        end else begin
          res_q[i] <= res_i[i];
          slp_q[i] <= slp_i[i];
          n_q[i]   <= n_i[i];
        end
        neg_q[i] <= neg_i[i];
      end
      sum_q  <= sum_i;
      zero_q <= zero_i;
    end
  end

  assign vld_o  = vld_q;
  assign sum_o  = sum_q;
  assign res_o  = res_q;
  assign slp_o  = slp_q;
  assign n_o    = n_q;
  assign neg_o  = neg_q;
  assign zero_o = zero_q;
endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for quaternion_normalizer_core
// Drives quaternions over the input stream with random gaps, predicts each
// unit quaternion with an exact integer search, and compares every output
// word field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import qn_pkg::*;

  localparam int unsigned IW  = QnInWidth;
  localparam int unsigned FB  = QnOutFracBits;
  localparam int unsigned OW  = FB + 2;
  localparam int unsigned IDW = qn_pad4(IW);
  localparam int unsigned ODW = qn_pad4(OW);
  localparam int unsigned NRAND = 650;
  localparam longint unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic          zero_norm;
    logic [OW-1:0] z;
    logic [OW-1:0] y;
    logic [OW-1:0] x;
    logic [OW-1:0] w;
  } unit_quat_t;

  typedef struct {
    logic [IW-1:0] c [4];
    logic          has_fixed;
    unit_quat_t    fixed;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [IDW-1:0] s_axis_tdata_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [ODW-1:0] m_axis_tdata_o;
  logic m_axis_tuser_o;

  unit_quat_t expected_units[$];
  int unsigned fail_count = 0;
  longint unsigned cycle_count = 0;
  bit rx_stall_enable = 1'b1;

  quaternion_normalizer_core dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o, .m_axis_tuser_o
  );

  // Clock, 2 ns period
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Gap length: mostly short, sometimes long
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Largest n in [0, 2^FB] with (2n-1)^2 * s <= a^2 * 2^(2FB+2)
  function automatic logic [OW-1:0] norm_component(logic [IW-1:0] raw, logic [127:0] s);
    logic          neg;
    logic [127:0]  mag, rhs, lhs, odd;
    logic [63:0]   lo, hi, mid;
    neg = raw[IW-1];
    mag = neg ? 128'((~{1'b0, raw}) + 1'b1) & ((128'd1 << IW) - 1) : 128'(raw);
    rhs = (mag * mag) << (2 * FB + 2);
    lo = 0;
    hi = 64'd1 << FB;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      odd = 128'(2 * mid - 1);
      lhs = odd * odd * s;
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return neg ? OW'(-lo) : OW'(lo);
  endfunction

  function automatic unit_quat_t normalize_quat(logic [IW-1:0] c [4]);
    unit_quat_t  u;
    logic [127:0] s;
    logic [127:0] m;
    s = 0;
    for (int i = 0; i < 4; i++) begin
      m = 128'(signed'(c[i]) < 0 ? -signed'({c[i][IW-1], c[i]}) : signed'({1'b0, c[i]}));
      s += m * m;
    end
    u = '0;
    if (s == 0) begin
      u.zero_norm = 1'b1;
      return u;
    end
    u.w = norm_component(c[0], s);
    u.x = norm_component(c[1], s);
    u.y = norm_component(c[2], s);
    u.z = norm_component(c[3], s);
    return u;
  endfunction

  // valid stays up between back-to-back words; dropped only for a gap
  task automatic send_word(logic [IW-1:0] c [4]);
    int unsigned g;
    g = gap_len();
    if (g != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= IDW'({c[3], c[2], c[1], c[0]});
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic send_row(stim_row_t row);
    unit_quat_t p;
    p = normalize_quat(row.c);
    if (row.has_fixed && p != row.fixed) begin
      $display("%0t tb: table row disagrees with prediction exp=%h act=%h",
               $time, row.fixed, p);
      fail_count++;
    end
    expected_units.push_back(row.has_fixed ? row.fixed : p);
    send_word(row.c);
  endtask

  // Output side: random backpressure and compare
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        unit_quat_t got, exp_u;
        got = {m_axis_tuser_o, m_axis_tdata_o[4*OW-1:0]};
        if (expected_units.size() == 0) begin
          $display("%0t unexpected word act=%h", $time, got);
          fail_count++;
        end else begin
          exp_u = expected_units.pop_front();
          if (got.w != exp_u.w)
            $display("%0t w_out exp=%0d act=%0d", $time, $signed(exp_u.w), $signed(got.w));
          if (got.x != exp_u.x)
            $display("%0t x_out exp=%0d act=%0d", $time, $signed(exp_u.x), $signed(got.x));
          if (got.y != exp_u.y)
            $display("%0t y_out exp=%0d act=%0d", $time, $signed(exp_u.y), $signed(got.y));
          if (got.z != exp_u.z)
            $display("%0t z_out exp=%0d act=%0d", $time, $signed(exp_u.z), $signed(got.z));
          if (got.zero_norm != exp_u.zero_norm)
            $display("%0t zero_norm exp=%0b act=%0b", $time, exp_u.zero_norm, got.zero_norm);
          if (got != exp_u) fail_count++;
        end
      end
      m_axis_tready_i <= !rx_stall_enable || ($urandom_range(0, 99) < 70) ||
                         ($urandom_range(0, 99) < 50 && cycle_count[6]);
    end
  end

  function automatic logic [IW-1:0] rand_comp();
    int unsigned k;
    k = $urandom_range(0, 9);
    case (k)
      0: return '0;
      1: return {1'b1, {(IW-1){1'b0}}};
      2: return {1'b0, {(IW-1){1'b1}}};
      3: return IW'($urandom_range(0, 15)) ^ {IW{$urandom_range(0, 1) == 1}};
      default: return IW'($urandom);
    endcase
  endfunction

  localparam logic [IW-1:0] CMAX = {1'b0, {(IW-1){1'b1}}};
  localparam logic [IW-1:0] CMIN = {1'b1, {(IW-1){1'b0}}};
  localparam logic [IW-1:0] CONE = IW'(1);
  localparam logic [IW-1:0] CNEG = '1;
  localparam logic [OW-1:0] UPOS = OW'(1 << FB);
  localparam logic [OW-1:0] UNEG = OW'(-(1 << FB));
  localparam logic [OW-1:0] UHALF = OW'(1 << (FB - 1));

  stim_row_t directed_rows[$];

  function automatic stim_row_t mk(logic [IW-1:0] w, x, y, z, bit f, unit_quat_t u);
    stim_row_t r;
    r.c[0] = w; r.c[1] = x; r.c[2] = y; r.c[3] = z;
    r.has_fixed = f;
    r.fixed = u;
    return r;
  endfunction

  initial begin
    stim_row_t row;
    int unsigned quiet;

    // Directed table: zero norm, unit components, extremes, ties
    directed_rows.push_back(mk('0, '0, '0, '0, 1, '{1'b1, '0, '0, '0, '0}));
    directed_rows.push_back(mk(CONE, '0, '0, '0, 1, '{1'b0, '0, '0, '0, UPOS}));
    directed_rows.push_back(mk('0, CNEG, '0, '0, 1, '{1'b0, '0, '0, UNEG, '0}));
    directed_rows.push_back(mk('0, '0, CMAX, '0, 1, '{1'b0, '0, UPOS, '0, '0}));
    directed_rows.push_back(mk('0, '0, '0, CMIN, 1, '{1'b0, UNEG, '0, '0, '0}));
    directed_rows.push_back(mk(CMIN, '0, '0, '0, 1, '{1'b0, '0, '0, '0, UNEG}));
    directed_rows.push_back(mk(CONE, CONE, CONE, CONE, 1, '{1'b0, UHALF, UHALF, UHALF, UHALF}));
    directed_rows.push_back(mk(CMIN, CMIN, CMIN, CMIN, 1,
                               '{1'b0, OW'(-UHALF), OW'(-UHALF), OW'(-UHALF), OW'(-UHALF)}));
    directed_rows.push_back(mk(CMAX, CMAX, CMAX, CMAX, 1, '{1'b0, UHALF, UHALF, UHALF, UHALF}));
    directed_rows.push_back(mk(CMAX, CMIN, CMAX, CMIN, 0, '0));
    directed_rows.push_back(mk(CONE, CMAX, '0, '0, 0, '0));
    directed_rows.push_back(mk(IW'(3), IW'(4), '0, '0, 0, '0));
    directed_rows.push_back(mk(CNEG, CONE, CONE, '0, 0, '0));
    directed_rows.push_back(mk(IW'(1), IW'(2), IW'(3), IW'(4), 0, '0));
    directed_rows.push_back(mk(IW'(4096), '0, '0, IW'(-4096), 0, '0));
    directed_rows.push_back(mk(IW'(16'h5555), IW'(16'haaaa), IW'(16'h00ff), IW'(16'hff00), 0, '0));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) send_row(directed_rows[i]);

    // Random part; one pause until the pipeline drains
    for (int n = 0; n < NRAND; n++) begin
      row.has_fixed = 1'b0;
      row.fixed = '0;
      for (int i = 0; i < 4; i++) row.c[i] = rand_comp();
      if (n == NRAND / 2) begin
        s_axis_tvalid_i <= 1'b0;
        @(posedge clk_i);
        while (expected_units.size() != 0) @(posedge clk_i);
      end
      rx_stall_enable = (n % 200) < 140;
      send_row(row);
    end
    s_axis_tvalid_i <= 1'b0;

    while (expected_units.size() != 0) @(posedge clk_i);
    quiet = 0;
    while (quiet < 4 * (FB + 4)) begin
      @(posedge clk_i);
      quiet++;
    end
    if (fail_count == 0 && expected_units.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/qn_pkg.sv
rtl/qn_prep.sv
rtl/qn_step.sv
rtl/quaternion_normalizer_core.sv
verif/testbench.sv
